// ----- rtl/core/gmd_pkg.sv -----
// Shared types, register indexes and helper functions of the grey-scale dilate/erode block.
package gmd_pkg;

   // Field widths of the transaction payloads and registers.
   localparam int GRAY_W      = 8;
   localparam int WIDTH_W     = 11;
   localparam int HEIGHT_W    = 13;
   localparam int RADIUS_W    = 3;
   localparam int ROW_W       = 13;
   localparam int CSR_INDEX_W = 3;
   localparam int CSR_DATA_W  = 16;

   // Upper bounds that size the internal operation record for any legal parameter set.
   localparam int COL_MAX_W  = 12;
   localparam int BANK_MAX_W = 5;
   localparam int ROWS_MAX   = 31;
   localparam int COLS_MAX   = 31;

   // Register indexes of the configuration port.
   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_IMAGE_WIDTH  = 3'd0,
      CSR_IMAGE_HEIGHT = 3'd1,
      CSR_RADIUS_X     = 3'd2,
      CSR_RADIUS_Y     = 3'd3,
      CSR_ERODE_MODE   = 3'd4
   } csr_index_type;

   typedef struct packed {
      logic [GRAY_W-1:0] gray_in;
      logic              is_padding;
   } req_type;

   typedef struct packed {
      logic [GRAY_W-1:0] gray_out;
      logic              frame_last;
   } rsp_type;

   typedef struct packed {
      logic [WIDTH_W-1:0]  image_width;
      logic [HEIGHT_W-1:0] image_height;
      logic [RADIUS_W-1:0] radius_x;
      logic [RADIUS_W-1:0] radius_y;
      logic                erode_mode;
   } cfg_type;

   localparam cfg_type CFG_RESET = '{
      image_width:  11'd640,
      image_height: 13'd480,
      radius_x:     3'd1,
      radius_y:     3'd1,
      erode_mode:   1'b0
   };

   // One classified transaction handed from the front end to the back end.
   typedef struct packed {
      logic                  wr_en;
      logic [GRAY_W-1:0]     sample;
      logic [COL_MAX_W-1:0]  col;
      logic [BANK_MAX_W-1:0] bank;
      logic [ROWS_MAX-1:0]   row_mask;
      logic                  emit;
      logic                  last;
      logic [COLS_MAX-1:0]   col_mask;
   } op_type;

   // Keeps the larger or, in erode mode, the smaller of two samples.
   function automatic logic [GRAY_W-1:0] pick(input logic [GRAY_W-1:0] a,
                                              input logic [GRAY_W-1:0] b,
                                              input logic take_min);
      if (take_min) begin
         return (b < a) ? b : a;
      end
      return (b > a) ? b : a;
   endfunction

   // Neutral element of the window reduction.
   function automatic logic [GRAY_W-1:0] neutral(input logic take_min);
      return take_min ? {GRAY_W{1'b1}} : {GRAY_W{1'b0}};
   endfunction

endpackage

// ----- rtl/core/gmd_fifo.sv -----
// Small register queue used between the front end, the back end and the result port.
module gmd_fifo #(
   parameter int DEPTH = 4,
   parameter type T = logic
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         push,
   input  T                             push_data,
   output logic                         full,
   input  logic                         pop,
   output T                             pop_data,
   output logic                         empty,
   output logic [$clog2(DEPTH+1)-1:0]   count
);
   localparam int PTR_W = $clog2(DEPTH);
   localparam int CNT_W = $clog2(DEPTH+1);

   T                 store_ff [DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff;
   logic [PTR_W-1:0] rd_ptr_ff;
   logic [CNT_W-1:0] count_ff;
   logic             wr;
   logic             rd;

   // Handshake qualification.
   assign full     = (count_ff == CNT_W'(DEPTH));
   assign empty    = (count_ff == '0);
   assign count    = count_ff;
   assign wr       = push && !full;
   assign rd       = pop && !empty;
   assign pop_data = store_ff[rd_ptr_ff];

   // Entry storage needs no reset.
   always_ff @(posedge clock) begin
      if (wr) begin
         store_ff[wr_ptr_ff] <= push_data;
      end
   end

   // Pointers and fill level.
   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         if (wr) begin
            wr_ptr_ff <= (wr_ptr_ff == PTR_W'(DEPTH-1)) ? '0 : wr_ptr_ff + 1'b1;
         end
         if (rd) begin
            rd_ptr_ff <= (rd_ptr_ff == PTR_W'(DEPTH-1)) ? '0 : rd_ptr_ff + 1'b1;
         end
         if (wr && !rd) begin
            count_ff <= count_ff + 1'b1;
         end else if (rd && !wr) begin
            count_ff <= count_ff - 1'b1;
         end
      end
   end

endmodule

// ----- rtl/core/gmd_front.sv -----
// Front end: registers, raster positions and classification of each input transaction.
module gmd_front #(
   parameter int MAX_WIDTH    = 1024,
   parameter int MAX_RADIUS_X = 7,
   parameter int MAX_RADIUS_Y = 7
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_push,
   output logic                               req_full,
   input  gmd_pkg::req_type                   req_data,
   input  logic                               csr_valid,
   output logic                               csr_ready,
   input  logic [gmd_pkg::CSR_INDEX_W-1:0]    csr_index,
   input  logic [gmd_pkg::CSR_DATA_W-1:0]     csr_wdata,
   input  logic                               opq_full,
   output logic                               opq_push,
   output gmd_pkg::op_type                    opq_data,
   output logic                               erode_mode
);
   import gmd_pkg::*;

   localparam int COL_W  = $clog2(MAX_WIDTH);
   localparam int RING   = 2*MAX_RADIUS_Y + 2;
   localparam int BANK_W = $clog2(RING);
   localparam int NROWS  = 2*MAX_RADIUS_Y + 1;
   localparam int NCOLS  = 2*MAX_RADIUS_X + 1;
   localparam int XW     = 16;
   localparam int LAG_W  = 27;

   typedef enum logic [1:0] {
      RC_IDLE,
      RC_MULT,
      RC_LOAD
   } recalc_state_type;

   recalc_state_type         state_ff;
   cfg_type                  cfg_ff;
   logic [COL_W-1:0]         in_col_ff, in_col_in;
   logic [ROW_W-1:0]         in_row_ff, in_row_in;
   logic [COL_W-1:0]         out_col_ff, out_col_in;
   logic [ROW_W-1:0]         out_row_ff, out_row_in;
   logic [BANK_W-1:0]        bank_ff, bank_in;
   logic signed [LAG_W-1:0]  lag_ff, lag_in;
   logic signed [LAG_W-1:0]  prod_ff;
   logic [XW-1:0]            d_ff;

   logic [WIDTH_W-1:0]       w_c;
   logic [HEIGHT_W-1:0]      h_c;
   logic [RADIUS_W-1:0]      rx_c, ry_c;
   logic                     clear;
   logic [COL_W-1:0]         ic, oc, oc_cl, oc_raw_cl;
   logic [ROW_W-1:0]         ir, orow;
   logic [BANK_W-1:0]        bank;
   logic signed [LAG_W-1:0]  lag, delta, lag_a;
   logic signed [LAG_W-1:0]  rdiff, wide_w;
   logic                     in_frame, ignore, wrap, emit, last, acc;
   logic [XW-1:0]            t;

   // Effective geometry after range limits.
   always_comb begin
      if (cfg_ff.image_width == '0) begin
         w_c = WIDTH_W'(1);
      end else if (XW'(cfg_ff.image_width) > XW'(MAX_WIDTH)) begin
         w_c = WIDTH_W'(MAX_WIDTH);
      end else begin
         w_c = cfg_ff.image_width;
      end
      h_c  = (cfg_ff.image_height == '0) ? HEIGHT_W'(1) : cfg_ff.image_height;
      rx_c = (XW'(cfg_ff.radius_x) > XW'(MAX_RADIUS_X)) ? RADIUS_W'(MAX_RADIUS_X)
                                                         : cfg_ff.radius_x;
      ry_c = (XW'(cfg_ff.radius_y) > XW'(MAX_RADIUS_Y)) ? RADIUS_W'(MAX_RADIUS_Y)
                                                         : cfg_ff.radius_y;
   end

   assign erode_mode = cfg_ff.erode_mode;
   assign csr_ready  = 1'b1;
   assign req_full   = opq_full || (state_ff != RC_IDLE);
   assign acc        = req_push && !req_full;

   // Positions as seen by the transaction, after an out-of-frame restart.
   always_comb begin
      clear     = (XW'(out_row_ff) >= XW'(h_c));
      ic        = clear ? '0 : in_col_ff;
      ir        = clear ? '0 : in_row_ff;
      oc        = clear ? '0 : out_col_ff;
      orow      = clear ? '0 : out_row_ff;
      bank      = clear ? '0 : bank_ff;
      lag       = clear ? '0 : lag_ff;
      oc_cl     = (XW'(oc) >= XW'(w_c)) ? COL_W'(w_c - 1'b1) : oc;
      oc_raw_cl = (XW'(out_col_ff) >= XW'(w_c)) ? COL_W'(w_c - 1'b1) : out_col_ff;
      rdiff     = LAG_W'(in_row_ff) - LAG_W'(out_row_ff);
      wide_w    = LAG_W'(w_c);
   end

   // Classification and position update of one transaction.
   always_comb begin
      in_frame = (XW'(ir) < XW'(h_c));
      ignore   = in_frame && req_data.is_padding;
      wrap     = (XW'(ic) + XW'(1) >= XW'(w_c));
      delta    = wrap ? (LAG_W'(w_c) - LAG_W'(ic)) : LAG_W'(1);
      lag_a    = lag + delta;
      emit     = (lag_a > $signed(LAG_W'(d_ff)));
      last     = emit && (XW'(orow) == XW'(h_c) - XW'(1))
                      && (XW'(oc_cl) == XW'(w_c) - XW'(1));

      in_col_in = wrap ? '0 : ic + 1'b1;
      in_row_in = wrap ? ir + 1'b1 : ir;
      if (wrap) begin
         bank_in = (bank == BANK_W'(RING-1)) ? '0 : bank + 1'b1;
      end else begin
         bank_in = bank;
      end
      out_col_in = oc;
      out_row_in = orow;
      lag_in     = lag_a;
      if (ignore) begin
         in_col_in = ic;
         in_row_in = ir;
         bank_in   = bank;
         lag_in    = lag;
      end else if (last) begin
         in_col_in  = '0;
         in_row_in  = '0;
         bank_in    = '0;
         out_col_in = '0;
         out_row_in = '0;
         lag_in     = '0;
      end else if (emit) begin
         lag_in = lag_a - LAG_W'(1);
         if (XW'(oc_cl) + XW'(1) >= XW'(w_c)) begin
            out_col_in = '0;
            out_row_in = orow + 1'b1;
         end else begin
            out_col_in = oc_cl + 1'b1;
         end
      end
   end

   // Operation record for the back end.
   always_comb begin
      opq_data        = '0;
      opq_data.wr_en  = in_frame && (XW'(ic) < XW'(w_c));
      opq_data.sample = req_data.gray_in;
      opq_data.col    = COL_MAX_W'(ic);
      opq_data.bank   = BANK_MAX_W'(bank);
      opq_data.emit   = emit;
      opq_data.last   = last;
      for (int i = 0; i < NROWS; i++) begin
         opq_data.row_mask[i] = (i <= 2*int'(ry_c)) && (XW'(i) <= XW'(ir))
                                && (XW'(ir) < XW'(h_c) + XW'(i));
      end
      t = XW'(oc_cl) + XW'(rx_c);
      for (int d = 0; d < NCOLS; d++) begin
         opq_data.col_mask[d] = (d <= 2*int'(rx_c)) && (t >= XW'(d))
                                && (t < XW'(w_c) + XW'(d));
      end
      opq_push = acc && !ignore;
   end

   // Registers, positions and the distance recalculation after a register write.
   always_ff @(posedge clock) begin
      d_ff <= XW'(ry_c) * XW'(w_c) + XW'(rx_c);
      if (reset) begin
         state_ff   <= RC_MULT;
         cfg_ff     <= CFG_RESET;
         in_col_ff  <= '0;
         in_row_ff  <= '0;
         out_col_ff <= '0;
         out_row_ff <= '0;
         bank_ff    <= '0;
         lag_ff     <= '0;
      end else begin
         case (state_ff)
            RC_IDLE: begin
            end
            RC_MULT: begin
               prod_ff  <= rdiff * wide_w;
               state_ff <= RC_LOAD;
            end
            RC_LOAD: begin
               lag_ff   <= prod_ff + LAG_W'(in_col_ff) - LAG_W'(oc_raw_cl);
               state_ff <= RC_IDLE;
            end
            default: begin
               state_ff <= RC_IDLE;
            end
         endcase
         if (csr_valid) begin
            state_ff <= RC_MULT;
            case (csr_index)
               CSR_IMAGE_WIDTH:  cfg_ff.image_width  <= csr_wdata[WIDTH_W-1:0];
               CSR_IMAGE_HEIGHT: cfg_ff.image_height <= csr_wdata[HEIGHT_W-1:0];
               CSR_RADIUS_X:     cfg_ff.radius_x     <= csr_wdata[RADIUS_W-1:0];
               CSR_RADIUS_Y:     cfg_ff.radius_y     <= csr_wdata[RADIUS_W-1:0];
               CSR_ERODE_MODE:   cfg_ff.erode_mode   <= csr_wdata[0];
               default: begin
               end
            endcase
         end
         if (acc) begin
            in_col_ff  <= in_col_in;
            in_row_ff  <= in_row_in;
            out_col_ff <= out_col_in;
            out_row_ff <= out_row_in;
            bank_ff    <= bank_in;
            lag_ff     <= lag_in;
         end
      end
   end

   // A register write holds off input while the distance is recalculated.
   a_csr_blocks_input: assert property (@(posedge clock) disable iff (reset)
      csr_valid |=> req_full)
      else $error("input accepted right after a register write");

endmodule

// ----- rtl/core/gmd_back.sv -----
// Back end: banked line stores, column extremes and the horizontal window reduction.
module gmd_back #(
   parameter int MAX_WIDTH    = 1024,
   parameter int MAX_RADIUS_X = 7,
   parameter int MAX_RADIUS_Y = 7
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              issue,
   input  gmd_pkg::op_type   op,
   input  logic              erode_mode,
   output logic              out_valid,
   output gmd_pkg::rsp_type  out_data,
   output logic [2:0]        pending
);
   import gmd_pkg::*;

   localparam int COL_W  = $clog2(MAX_WIDTH);
   localparam int RING   = 2*MAX_RADIUS_Y + 2;
   localparam int BANK_W = $clog2(RING);
   localparam int NROWS  = 2*MAX_RADIUS_Y + 1;
   localparam int NCOLS  = 2*MAX_RADIUS_X + 1;
   localparam int NG2    = (NROWS + 3) / 4;
   localparam int NG4    = (NCOLS + 3) / 4;

   logic [RING-1:0][GRAY_W-1:0] rd_all;
   logic [GRAY_W-1:0]           ident;
   logic                        v1_ff, v2_ff, v3_ff, v4_ff, out_valid_ff;
   op_type                      op1_ff, op2_ff, op3_ff;
   logic                        last4_ff, emit4_ff;
   logic [GRAY_W-1:0]           rowv [NROWS];
   logic [GRAY_W-1:0]           g2_in [NG2];
   logic [GRAY_W-1:0]           g2_ff [NG2];
   logic [GRAY_W-1:0]           colv;
   logic [GRAY_W-1:0]           shift_ff [NCOLS];
   logic [GRAY_W-1:0]           hv [NCOLS];
   logic [GRAY_W-1:0]           h4_in [NG4];
   logic [GRAY_W-1:0]           h4_ff [NG4];
   logic [GRAY_W-1:0]           res;

   assign ident = neutral(erode_mode);

   // One line store bank per ring row, all read at the same column.
   for (genvar b = 0; b < RING; b++) begin : g_bank
      logic [GRAY_W-1:0] mem [MAX_WIDTH];
      logic [GRAY_W-1:0] rd_ff;
      always_ff @(posedge clock) begin
         if (issue) begin
            if (op.wr_en && (op.bank[BANK_W-1:0] == BANK_W'(b))) begin
               mem[op.col[COL_W-1:0]] <= op.sample;
            end
            rd_ff <= mem[op.col[COL_W-1:0]];
         end
      end
      assign rd_all[b] = rd_ff;
   end

   // Vertical reduction, first level: select rows of the window and fold groups of four.
   always_comb begin
      int idx;
      for (int i = 0; i < NROWS; i++) begin
         idx = int'(op1_ff.bank[BANK_W-1:0]) - i;
         if (idx < 0) begin
            idx = idx + RING;
         end
         if (!op1_ff.row_mask[i]) begin
            rowv[i] = ident;
         end else if (i == 0) begin
            rowv[i] = op1_ff.sample;
         end else begin
            rowv[i] = rd_all[BANK_W'(idx)];
         end
      end
      for (int g = 0; g < NG2; g++) begin
         g2_in[g] = ident;
         for (int k = 0; k < 4; k++) begin
            if (g*4 + k < NROWS) begin
               g2_in[g] = pick(g2_in[g], rowv[g*4 + k], erode_mode);
            end
         end
      end
   end

   // Vertical reduction, final level: the column extreme.
   always_comb begin
      colv = ident;
      for (int g = 0; g < NG2; g++) begin
         colv = pick(colv, g2_ff[g], erode_mode);
      end
   end

   // Horizontal reduction, first level over the masked column extremes.
   always_comb begin
      for (int d = 0; d < NCOLS; d++) begin
         hv[d] = op3_ff.col_mask[d] ? shift_ff[d] : ident;
      end
      for (int g = 0; g < NG4; g++) begin
         h4_in[g] = ident;
         for (int k = 0; k < 4; k++) begin
            if (g*4 + k < NCOLS) begin
               h4_in[g] = pick(h4_in[g], hv[g*4 + k], erode_mode);
            end
         end
      end
   end

   // Horizontal reduction, final level.
   always_comb begin
      res = ident;
      for (int g = 0; g < NG4; g++) begin
         res = pick(res, h4_ff[g], erode_mode);
      end
   end

   // Payload stages; the pipeline never stalls.
   always_ff @(posedge clock) begin
      op1_ff <= op;
      op2_ff <= op1_ff;
      op3_ff <= op2_ff;
      g2_ff  <= g2_in;
      h4_ff  <= h4_in;
      emit4_ff <= op3_ff.emit;
      last4_ff <= op3_ff.last;
      out_data.gray_out   <= res;
      out_data.frame_last <= last4_ff;
      if (v2_ff) begin
         shift_ff[0] <= colv;
         for (int d = 1; d < NCOLS; d++) begin
            shift_ff[d] <= shift_ff[d-1];
         end
      end
   end

   // Stage valid bits.
   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff        <= 1'b0;
         v2_ff        <= 1'b0;
         v3_ff        <= 1'b0;
         v4_ff        <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         v1_ff        <= issue;
         v2_ff        <= v1_ff;
         v3_ff        <= v2_ff;
         v4_ff        <= v3_ff;
         out_valid_ff <= v4_ff && emit4_ff;
      end
   end

   // Results still on their way to the result queue.
   assign pending = 3'(v1_ff && op1_ff.emit) + 3'(v2_ff && op2_ff.emit)
                  + 3'(v3_ff && op3_ff.emit) + 3'(v4_ff && emit4_ff) + 3'(out_valid_ff);
   assign out_valid = out_valid_ff;

   // Every issued operation that yields a result delivers it after a fixed latency.
   a_fixed_latency: assert property (@(posedge clock) disable iff (reset)
      issue && op.emit |-> ##5 out_valid)
      else $error("result missing at the end of the pipeline");

endmodule

// ----- rtl/core/gray_morph_dilate_erode.sv -----
// Top level of the grey-scale dilate/erode block over a clipped rectangular window.
//
//   Channel  Direction  Handshake                Content
//   req_     in         push / full              gray_in, is_padding
//   rsp_     out        pop / empty              gray_out, frame_last
//   csr_     in         csr_valid / csr_ready    register index, write data
//
// One transaction per clock is taken while full is low; the operation of the transaction that completes a
// window passes the line store read and the two registered reduction trees before its result leaves.
// Reset is synchronous; the block holds full after reset and after each register write while the
// row distance is recalculated with one multiplier, in a multiply state and then a load state.
// The result queue has 8 entries; operations are issued only when a result place is free,
// so a stalled result port backs up through the 4-entry operation queue to full.
module gray_morph_dilate_erode #(
   parameter int MAX_WIDTH    = 1024,
   parameter int MAX_RADIUS_X = 7,
   parameter int MAX_RADIUS_Y = 7
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_push,
   output logic                             req_full,
   input  gmd_pkg::req_type                 req_data,
   input  logic                             rsp_pop,
   output logic                             rsp_empty,
   output gmd_pkg::rsp_type                 rsp_data,
   input  logic                             csr_valid,
   output logic                             csr_ready,
   input  logic [gmd_pkg::CSR_INDEX_W-1:0]  csr_index,
   input  logic [gmd_pkg::CSR_DATA_W-1:0]   csr_wdata
);
   import gmd_pkg::*;

   localparam int OPQ_DEPTH  = 4;
   localparam int RSPQ_DEPTH = 8;
   localparam int OPQ_CW     = $clog2(OPQ_DEPTH+1);
   localparam int RSPQ_CW    = $clog2(RSPQ_DEPTH+1);
   localparam int SUM_W      = RSPQ_CW + 2;

   logic                opq_push, opq_full, opq_empty, issue;
   op_type              opq_in, opq_out;
   logic [OPQ_CW-1:0]   opq_count;
   logic                erode_mode;
   logic                bk_valid;
   rsp_type             bk_data;
   logic [2:0]          pending;
   logic                rspq_full;
   logic [RSPQ_CW-1:0]  rspq_count;
   logic [SUM_W-1:0]    used;

   gmd_front #(
      .MAX_WIDTH    (MAX_WIDTH),
      .MAX_RADIUS_X (MAX_RADIUS_X),
      .MAX_RADIUS_Y (MAX_RADIUS_Y)
   ) u_front (
      .clock      (clock),
      .reset      (reset),
      .req_push   (req_push),
      .req_full   (req_full),
      .req_data   (req_data),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata),
      .opq_full   (opq_full),
      .opq_push   (opq_push),
      .opq_data   (opq_in),
      .erode_mode (erode_mode)
   );

   gmd_fifo #(
      .DEPTH (OPQ_DEPTH),
      .T     (op_type)
   ) u_opq (
      .clock     (clock),
      .reset     (reset),
      .push      (opq_push),
      .push_data (opq_in),
      .full      (opq_full),
      .pop       (issue),
      .pop_data  (opq_out),
      .empty     (opq_empty),
      .count     (opq_count)
   );

   // Issue only when the result queue can take everything already in flight.
   assign used  = SUM_W'(rspq_count) + SUM_W'(pending);
   assign issue = !opq_empty && (used < SUM_W'(RSPQ_DEPTH));

   gmd_back #(
      .MAX_WIDTH    (MAX_WIDTH),
      .MAX_RADIUS_X (MAX_RADIUS_X),
      .MAX_RADIUS_Y (MAX_RADIUS_Y)
   ) u_back (
      .clock      (clock),
      .reset      (reset),
      .issue      (issue),
      .op         (opq_out),
      .erode_mode (erode_mode),
      .out_valid  (bk_valid),
      .out_data   (bk_data),
      .pending    (pending)
   );

   gmd_fifo #(
      .DEPTH (RSPQ_DEPTH),
      .T     (rsp_type)
   ) u_rspq (
      .clock     (clock),
      .reset     (reset),
      .push      (bk_valid),
      .push_data (bk_data),
      .full      (rspq_full),
      .pop       (rsp_pop),
      .pop_data  (rsp_data),
      .empty     (rsp_empty),
      .count     (rspq_count)
   );

   // Result queue space is reserved before an operation is issued.
   a_rspq_no_overflow: assert property (@(posedge clock) disable iff (reset)
      bk_valid |-> !rspq_full)
      else $error("result written into a full result queue");

   a_credit_bound: assert property (@(posedge clock) disable iff (reset)
      used <= SUM_W'(RSPQ_DEPTH))
      else $error("results in flight exceed the result queue");

   a_opq_no_overflow: assert property (@(posedge clock) disable iff (reset)
      opq_push |-> (!opq_full && (opq_count < OPQ_CW'(OPQ_DEPTH))))
      else $error("operation written into a full operation queue");

endmodule

// ----- bench/tb.sv -----
// Self-checking testbench of the grey-scale dilate/erode block.
module tb;
   import gmd_pkg::*;

   localparam int LW         = 1024;
   localparam int RING       = 16;
   localparam int ITEM_GOAL  = 1850;
   localparam int LIMIT      = 600000;
   localparam int DRAIN_WAIT = 30;

   logic clock;
   logic reset;
   logic req_push;
   logic req_full;
   req_type req_data;
   logic rsp_pop;
   logic rsp_empty;
   rsp_type rsp_data;
   logic csr_valid;
   logic csr_ready;
   logic [CSR_INDEX_W-1:0] csr_index;
   logic [CSR_DATA_W-1:0] csr_wdata;

   gray_morph_dilate_erode u_top (
      .clock     (clock),
      .reset     (reset),
      .req_push  (req_push),
      .req_full  (req_full),
      .req_data  (req_data),
      .rsp_pop   (rsp_pop),
      .rsp_empty (rsp_empty),
      .rsp_data  (rsp_data),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   // Clock with a period of 10.
   always begin
      clock = 1'b1;
      #5;
      clock = 1'b0;
      #5;
   end

   // Mirror of the block's state and registers.
   logic [7:0] pixel_rows [RING*LW];
   int unsigned in_col, in_row, out_col, out_row;
   logic [WIDTH_W-1:0] width_reg;
   logic [HEIGHT_W-1:0] height_reg;
   logic [RADIUS_W-1:0] rad_x_reg, rad_y_reg;
   logic erode_reg;

   req_type pixel_queue [$];
   rsp_type window_queue [$];
   int unsigned items_sent, results_seen, frames_run, mismatches, cycles;
   bit no_idle;

   // Works out the window result, if any, that one accepted transaction causes.
   function automatic bit window_step(input req_type it, output rsp_type res);
      int unsigned w, h, rx, ry, r0, r1, c0, c1, oc;
      longint unsigned got, need;
      logic [7:0] acc, v;
      bit last;
      res = '0;
      w = width_reg;
      h = height_reg;
      rx = rad_x_reg;
      ry = rad_y_reg;
      if (w < 1) w = 1;
      if (w > LW) w = LW;
      if (h < 1) h = 1;
      if (out_row >= h) begin
         in_col = 0; in_row = 0; out_col = 0; out_row = 0;
      end
      if (in_row < h) begin
         if (it.is_padding) return 1'b0;
         if (in_col < w) pixel_rows[(in_row % RING) * LW + in_col] = it.gray_in;
      end
      if (in_col + 1 >= w) begin
         in_col = 0;
         in_row++;
      end else begin
         in_col++;
      end
      oc = (out_col < w) ? out_col : w - 1;
      got = longint'(in_row) * w + in_col;
      need = longint'(out_row) * w + oc + longint'(ry) * w + rx;
      if (got < need + 1) return 1'b0;
      out_col = oc;
      r0 = (out_row > ry) ? out_row - ry : 0;
      r1 = (out_row + ry < h) ? out_row + ry : h - 1;
      c0 = (out_col > rx) ? out_col - rx : 0;
      c1 = (out_col + rx < w) ? out_col + rx : w - 1;
      acc = erode_reg ? 8'hFF : 8'h00;
      for (int i = r0; i <= r1; i++) begin
         for (int j = c0; j <= c1; j++) begin
            v = pixel_rows[(i % RING) * LW + (j % LW)];
            if (erode_reg ? (v < acc) : (v > acc)) acc = v;
         end
      end
      last = (out_row == h - 1) && (out_col == w - 1);
      res.gray_out = acc;
      res.frame_last = last;
      if (last) begin
         in_col = 0; in_row = 0; out_col = 0; out_row = 0;
      end else if (out_col + 1 >= w) begin
         out_col = 0;
         out_row++;
      end else begin
         out_col++;
      end
      return 1'b1;
   endfunction

   // Gap lengths: mostly none or short, now and then long.
   function automatic int idle_gap();
      int r;
      r = $urandom_range(0, 99);
      if (no_idle || r < 60) return 0;
      if (r < 92) return $urandom_range(1, 3);
      return $urandom_range(8, 40);
   endfunction

   // Driver: offers pending pixels and predicts each accepted transaction.
   int send_gap;
   always @(posedge clock) begin
      rsp_type res;
      if (reset) begin
         req_push <= 1'b0;
         req_data <= '0;
         send_gap <= 0;
      end else if (!(req_push && req_full)) begin
         if (req_push) begin
            items_sent++;
            if (window_step(req_data, res)) window_queue.push_back(res);
         end
         if (send_gap > 0) begin
            send_gap <= send_gap - 1;
            req_push <= 1'b0;
         end else if (pixel_queue.size() > 0) begin
            req_data <= pixel_queue.pop_front();
            req_push <= 1'b1;
            send_gap <= idle_gap();
         end else begin
            req_push <= 1'b0;
         end
      end
   end

   // Monitor: checks each result transaction against the oldest expectation.
   int pop_gap, hold_left;
   always @(posedge clock) begin
      rsp_type want;
      if (reset) begin
         rsp_pop <= 1'b0;
         pop_gap <= 0;
         hold_left <= 0;
      end else begin
         if (rsp_pop && !rsp_empty) begin
            results_seen++;
            if (window_queue.size() == 0) begin
               mismatches++;
               if (mismatches <= 10)
                  $display("unexpected result: gray_out %0d frame_last %0d",
                           rsp_data.gray_out, rsp_data.frame_last);
            end else begin
               want = window_queue.pop_front();
               if (rsp_data !== want) begin
                  mismatches++;
                  if (mismatches <= 10)
                     $display("result %0d: expected gray_out %0d frame_last %0d, got %0d %0d",
                              results_seen, want.gray_out, want.frame_last,
                              rsp_data.gray_out, rsp_data.frame_last);
               end
            end
            // Long back-pressure so that the block fills and stalls its input.
            if (results_seen == 1100) hold_left <= 400;
         end
         if (hold_left > 0) begin
            hold_left <= hold_left - 1;
            rsp_pop <= 1'b0;
         end else if (pop_gap > 0) begin
            pop_gap <= pop_gap - 1;
            rsp_pop <= 1'b0;
         end else begin
            rsp_pop <= 1'b1;
            pop_gap <= idle_gap();
         end
      end
   end

   // Watchdog.
   always @(posedge clock) begin
      cycles++;
      if (cycles > LIMIT) begin
         $display("timeout after %0d cycles", cycles);
         $display("simulation failed");
         $finish;
      end
   end

   // Waits until every offered pixel is taken and every result has come.
   task automatic wait_idle();
      while (pixel_queue.size() > 0 || req_push || window_queue.size() > 0)
         @(posedge clock);
      repeat (DRAIN_WAIT) @(posedge clock);
   endtask

   // One register write; valid stays high for a following write.
   task automatic csr_write(input csr_index_type idx, input int unsigned value);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value[CSR_DATA_W-1:0];
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      case (idx)
         CSR_IMAGE_WIDTH:  width_reg = value[WIDTH_W-1:0];
         CSR_IMAGE_HEIGHT: height_reg = value[HEIGHT_W-1:0];
         CSR_RADIUS_X:     rad_x_reg = value[RADIUS_W-1:0];
         CSR_RADIUS_Y:     rad_y_reg = value[RADIUS_W-1:0];
         CSR_ERODE_MODE:   erode_reg = value[0];
         default: ;
      endcase
   endtask

   function automatic logic [7:0] any_gray();
      int r;
      r = $urandom_range(0, 9);
      if (r == 0) return 8'h00;
      if (r == 1) return 8'hFF;
      return $urandom_range(0, 255);
   endfunction

   // Configures the block and queues one whole frame followed by its drain transactions.
   task automatic run_frame(input int unsigned w, input int unsigned h, input int unsigned rx,
                            input int unsigned ry, input bit er, input int pad_pct);
      int unsigned ew, eh, drain;
      req_type it;
      wait_idle();
      csr_write(CSR_IMAGE_WIDTH, w);
      csr_write(CSR_IMAGE_HEIGHT, h);
      csr_write(CSR_RADIUS_X, rx);
      csr_write(CSR_RADIUS_Y, ry);
      csr_write(CSR_ERODE_MODE, er);
      csr_valid <= 1'b0;
      ew = (w == 0) ? 1 : (w > LW ? LW : w);
      eh = (h == 0) ? 1 : h;
      for (int p = 0; p < ew * eh; p++) begin
         // Padding inside the frame is dropped by the block.
         if (p > 0 && $urandom_range(0, 99) < pad_pct) begin
            it.gray_in = any_gray();
            it.is_padding = 1'b1;
            pixel_queue.push_back(it);
         end
         it.gray_in = any_gray();
         it.is_padding = 1'b0;
         pixel_queue.push_back(it);
      end
      drain = ry * ew + rx;
      for (int d = 0; d < drain; d++) begin
         it.gray_in = any_gray();
         it.is_padding = $urandom_range(0, 1);
         pixel_queue.push_back(it);
      end
      frames_run++;
   endtask

   initial begin
      reset = 1'b1;
      req_push = 1'b0;
      req_data = '0;
      rsp_pop = 1'b0;
      csr_valid = 1'b0;
      csr_index = '0;
      csr_wdata = '0;
      width_reg = 11'd640;
      height_reg = 13'd480;
      rad_x_reg = 3'd1;
      rad_y_reg = 3'd1;
      erode_reg = 1'b0;
      in_col = 0; in_row = 0; out_col = 0; out_row = 0;
      for (int k = 0; k < RING * LW; k++) pixel_rows[k] = 8'h00;
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed part: smallest frames, zero sizes, largest radii and widths.
      run_frame(1, 1, 0, 0, 1'b0, 0);
      run_frame(0, 0, 0, 0, 1'b1, 0);
      run_frame(3, 2, 1, 1, 1'b0, 30);
      run_frame(4, 3, 7, 7, 1'b1, 10);
      wait_idle();
      csr_write(CSR_IMAGE_HEIGHT, 8191);
      csr_write(CSR_IMAGE_WIDTH, 1024);
      csr_valid <= 1'b0;
      run_frame(2047, 1, 7, 0, 1'b0, 0);

      // Random frames; the sender pauses until all results are in before each one.
      while (items_sent + pixel_queue.size() < ITEM_GOAL) begin
         no_idle = ($urandom_range(0, 4) == 0);
         if ($urandom_range(0, 9) == 0)
            run_frame($urandom_range(20, 64), $urandom_range(1, 4), $urandom_range(0, 7),
                      $urandom_range(0, 7), $urandom_range(0, 1), 5);
         else
            run_frame($urandom_range(1, 12), $urandom_range(1, 10), $urandom_range(0, 7),
                      $urandom_range(0, 7), $urandom_range(0, 1), 5);
      end
      wait_idle();
      no_idle = 1'b0;

      $display("%0d frames, %0d transactions in, %0d results, dilate and erode,",
               frames_run, items_sent, results_seen);
      $display("widths 0 to 2047, heights 0 to 10, radii 0 to 7, %0d mismatches", mismatches);
      if (mismatches == 0 && window_queue.size() == 0) begin
         $display("simulation ok");
      end else begin
         $display("simulation failed");
      end
      $finish;
   end

endmodule

// ----- files.f -----
rtl/core/gmd_pkg.sv
rtl/core/gmd_fifo.sv
rtl/core/gmd_front.sv
rtl/core/gmd_back.sv
rtl/core/gray_morph_dilate_erode.sv
bench/tb.sv
